FILE: rtl/mme_pkg.sv
// mme_pkg: shared widths, codes, tag struct and helpers for the matrix multiply engine
// depends on nothing; used by every module under rtl

package mme_pkg;

   localparam int MAX_DIM     = 8;
   localparam int DEPTH       = MAX_DIM * MAX_DIM;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int DIM_W       = 4;
   localparam int POS_W       = 3;
   localparam int ELEM_W      = 16;
   localparam int PROD_W      = 2 * ELEM_W;
   localparam int SUM_W       = 35;
   localparam int FUNC_W      = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD_A = 2'd0,
      FUNC_LOAD_B = 2'd1,
      FUNC_RUN    = 2'd2
   } func_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS_A    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INNER_DIM = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLS_B    = 2'd2;

   // control that travels with each read through the mac pipeline
   typedef struct packed {
      logic             valid;
      logic             first;
      logic             last_k;
      logic             last_elem;
      logic             zero;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
   } tag_type;

   function automatic logic [DIM_W-1:0] dim_limit(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] lim;
      lim = DIM_W'(MAX_DIM);
      return (v > lim) ? lim : v;
   endfunction

endpackage

FILE: rtl/matrix_multiply_engine.sv
// matrix_multiply_engine: top level, config registers, load path, element stores,
// sequencer and shared mac; depends on mme_pkg, mme_store, mme_seq, mme_mac
//
// channel   direction  handshake                   payload
// request   in         start && !busy              req_func, req_element_index,
//                                                  req_element_value
// response  out        rsp_strobe, one cycle       rsp_product_sum, rsp_out_row,
//                                                  rsp_out_col, rsp_last_result
// csr       in         csr_write_enable            csr_index, csr_write_data
//
// a load word is written into its store when accepted and busy stays low
// a run keeps busy high while the shared mac makes rows * cols * max(inner, 1)
// store reads, one per cycle, and while the pipeline drains; an empty shape
// emits nothing and leaves busy low
// each result word passes the store read, product and result registers after the
// last inner step of its element and comes out in row-major order
// reset clears control and sets the config registers to 1; stores hold garbage until loaded
// the receiver cannot stall, so every result word goes out the cycle it is ready

module matrix_multiply_engine (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [mme_pkg::FUNC_W-1:0]           req_func,
   input  logic [mme_pkg::ADDR_W-1:0]           req_element_index,
   input  logic signed [mme_pkg::ELEM_W-1:0]    req_element_value,
   output logic                                 rsp_strobe,
   output logic signed [mme_pkg::SUM_W-1:0]     rsp_product_sum,
   output logic [mme_pkg::POS_W-1:0]            rsp_out_row,
   output logic [mme_pkg::POS_W-1:0]            rsp_out_col,
   output logic                                 rsp_last_result,
   input  logic                                 csr_write_enable,
   input  logic [mme_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [mme_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   logic [mme_pkg::DIM_W-1:0]   rows_a_ff, rows_a_in;
   logic [mme_pkg::DIM_W-1:0]   inner_dim_ff, inner_dim_in;
   logic [mme_pkg::DIM_W-1:0]   cols_b_ff, cols_b_in;
   logic                        accept, run_start, wr_a, wr_b;
   logic                        seq_active, pipe_busy;
   mme_pkg::tag_type            tag;
   logic [mme_pkg::ADDR_W-1:0]  a_addr, b_addr;
   logic [mme_pkg::ELEM_W-1:0]  a_data, b_data;

   assign accept    = start && !busy;
   assign run_start = accept && (req_func == mme_pkg::FUNC_RUN);
   assign wr_a      = accept && (req_func == mme_pkg::FUNC_LOAD_A);
   assign wr_b      = accept && (req_func == mme_pkg::FUNC_LOAD_B);
   assign busy      = seq_active || pipe_busy;

   always_comb begin
      rows_a_in    = rows_a_ff;
      inner_dim_in = inner_dim_ff;
      cols_b_in    = cols_b_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            mme_pkg::CSR_ROWS_A:    rows_a_in    = csr_write_data;
            mme_pkg::CSR_INNER_DIM: inner_dim_in = csr_write_data;
            mme_pkg::CSR_COLS_B:    cols_b_in    = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= mme_pkg::DIM_W'(1);
         inner_dim_ff <= mme_pkg::DIM_W'(1);
         cols_b_ff    <= mme_pkg::DIM_W'(1);
      end else begin
         rows_a_ff    <= rows_a_in;
         inner_dim_ff <= inner_dim_in;
         cols_b_ff    <= cols_b_in;
      end
   end

   mme_store u_store_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (req_element_index),
      .wr_data (req_element_value),
      .rd_addr (a_addr),
      .rd_data (a_data)
   );

   mme_store u_store_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (req_element_index),
      .wr_data (req_element_value),
      .rd_addr (b_addr),
      .rd_data (b_data)
   );

   mme_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .run_start (run_start),
      .num_rows  (mme_pkg::dim_limit(rows_a_ff)),
      .num_inner (mme_pkg::dim_limit(inner_dim_ff)),
      .num_cols  (mme_pkg::dim_limit(cols_b_ff)),
      .tag       (tag),
      .a_addr    (a_addr),
      .b_addr    (b_addr),
      .active    (seq_active)
   );

   mme_mac u_mac (
      .clock           (clock),
      .reset           (reset),
      .tag             (tag),
      .a_data          ($signed(a_data)),
      .b_data          ($signed(b_data)),
      .pipe_busy       (pipe_busy),
      .rsp_strobe      (rsp_strobe),
      .rsp_product_sum (rsp_product_sum),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_last_result (rsp_last_result)
   );

   // more words of the same run are still in flight
   a_more_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_result |-> busy)
      else $error("non-final result word with engine idle");

   // a load never starts the sequencer
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      accept && (wr_a || wr_b) |=> !seq_active)
      else $error("sequencer active after a load word");

   // a run with empty result shape emits nothing
   a_empty_run: assert property (@(posedge clock) disable iff (reset)
      run_start && (mme_pkg::dim_limit(rows_a_ff) == '0 ||
                    mme_pkg::dim_limit(cols_b_ff) == '0) |=> !busy)
      else $error("empty run left engine busy");

   // no result word appears while the engine sat idle the cycle before
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result word without a run in flight");

endmodule

FILE: rtl/mme_store.sv
// mme_store: 64 x 16 element store, one write port and one registered read port
// depends on mme_pkg

module mme_store (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [mme_pkg::ADDR_W-1:0]         wr_addr,
   input  logic [mme_pkg::ELEM_W-1:0]         wr_data,
   input  logic [mme_pkg::ADDR_W-1:0]         rd_addr,
   output logic [mme_pkg::ELEM_W-1:0]         rd_data
);

   logic [mme_pkg::ELEM_W-1:0] store_ff [mme_pkg::DEPTH];
   logic [mme_pkg::ELEM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/mme_seq.sv
// mme_seq: run sequencer, walks row, column and inner index and forms store addresses
// depends on mme_pkg

module mme_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          run_start,
   input  logic [mme_pkg::DIM_W-1:0]     num_rows,
   input  logic [mme_pkg::DIM_W-1:0]     num_inner,
   input  logic [mme_pkg::DIM_W-1:0]     num_cols,
   output mme_pkg::tag_type              tag,
   output logic [mme_pkg::ADDR_W-1:0]    a_addr,
   output logic [mme_pkg::ADDR_W-1:0]    b_addr,
   output logic                          active
);

   logic                         active_ff, active_in;
   logic [mme_pkg::POS_W-1:0]    r_ff, r_in, c_ff, c_in, k_ff, k_in;
   logic [mme_pkg::DIM_W-1:0]    nr_ff, nr_in, nk_ff, nk_in, nc_ff, nc_in;
   logic                         last_r, last_c, last_k, zero_k;

   assign zero_k = (nk_ff == '0);
   assign last_k = zero_k || ({1'b0, k_ff} == nk_ff - mme_pkg::DIM_W'(1));
   assign last_c = ({1'b0, c_ff} == nc_ff - mme_pkg::DIM_W'(1));
   assign last_r = ({1'b0, r_ff} == nr_ff - mme_pkg::DIM_W'(1));

   assign a_addr = mme_pkg::ADDR_W'(r_ff) * mme_pkg::ADDR_W'(nk_ff)
                 + mme_pkg::ADDR_W'(k_ff);
   assign b_addr = mme_pkg::ADDR_W'(k_ff) * mme_pkg::ADDR_W'(nc_ff)
                 + mme_pkg::ADDR_W'(c_ff);

   always_comb begin
      tag.valid     = active_ff;
      tag.first     = (k_ff == '0);
      tag.last_k    = last_k;
      tag.last_elem = last_k && last_c && last_r;
      tag.zero      = zero_k;
      tag.row       = r_ff;
      tag.col       = c_ff;
   end

   always_comb begin
      active_in = active_ff;
      r_in      = r_ff;
      c_in      = c_ff;
      k_in      = k_ff;
      nr_in     = nr_ff;
      nk_in     = nk_ff;
      nc_in     = nc_ff;
      if (run_start) begin
         // an empty result leaves the sequencer idle
         active_in = (num_rows != '0) && (num_cols != '0);
         r_in      = '0;
         c_in      = '0;
         k_in      = '0;
         nr_in     = num_rows;
         nk_in     = num_inner;
         nc_in     = num_cols;
      end else if (active_ff) begin
         if (!last_k) begin
            k_in = k_ff + mme_pkg::POS_W'(1);
         end else begin
            k_in = '0;
            if (!last_c) begin
               c_in = c_ff + mme_pkg::POS_W'(1);
            end else begin
               c_in = '0;
               if (!last_r) begin
                  r_in = r_ff + mme_pkg::POS_W'(1);
               end else begin
                  active_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
      r_ff  <= r_in;
      c_ff  <= c_in;
      k_ff  <= k_in;
      nr_ff <= nr_in;
      nk_ff <= nk_in;
      nc_ff <= nc_in;
   end

   assign active = active_ff;

endmodule

FILE: rtl/mme_mac.sv
// mme_mac: shared multiply-accumulate unit, product stage then accumulate into the result word
// depends on mme_pkg

module mme_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  mme_pkg::tag_type                    tag,
   input  logic signed [mme_pkg::ELEM_W-1:0]   a_data,
   input  logic signed [mme_pkg::ELEM_W-1:0]   b_data,
   output logic                                pipe_busy,
   output logic                                rsp_strobe,
   output logic signed [mme_pkg::SUM_W-1:0]    rsp_product_sum,
   output logic [mme_pkg::POS_W-1:0]           rsp_out_row,
   output logic [mme_pkg::POS_W-1:0]           rsp_out_col,
   output logic                                rsp_last_result
);

   mme_pkg::tag_type                    s1_tag_ff, s2_tag_ff;
   logic signed [mme_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic signed [mme_pkg::SUM_W-1:0]    acc_ff, acc_in, prod_ext;
   logic                                strobe_ff, strobe_in;
   logic signed [mme_pkg::SUM_W-1:0]    sum_ff;
   logic [mme_pkg::POS_W-1:0]           row_ff, col_ff;
   logic                                last_ff;

   // zero inner dimension: one pass per element that adds nothing
   always_comb begin
      if (s1_tag_ff.zero) begin
         prod_in = '0;
      end else begin
         prod_in = a_data * b_data;
      end
   end

   assign prod_ext = {{(mme_pkg::SUM_W - mme_pkg::PROD_W){prod_ff[mme_pkg::PROD_W-1]}},
                      prod_ff};
   assign acc_in   = s2_tag_ff.first ? prod_ext : acc_ff + prod_ext;
   assign strobe_in = s2_tag_ff.valid && s2_tag_ff.last_k;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff <= '0;
         s2_tag_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         s1_tag_ff <= tag;
         s2_tag_ff <= s1_tag_ff;
         strobe_ff <= strobe_in;
      end
      prod_ff <= prod_in;
      if (s2_tag_ff.valid) begin
         acc_ff <= acc_in;
      end
      if (strobe_in) begin
         sum_ff  <= acc_in;
         row_ff  <= s2_tag_ff.row;
         col_ff  <= s2_tag_ff.col;
         last_ff <= s2_tag_ff.last_elem;
      end
   end

   assign pipe_busy       = s1_tag_ff.valid || s2_tag_ff.valid;
   assign rsp_strobe      = strobe_ff;
   assign rsp_product_sum = sum_ff;
   assign rsp_out_row     = row_ff;
   assign rsp_out_col     = col_ff;
   assign rsp_last_result = strobe_ff && last_ff;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for matrix_multiply_engine, with a product tracker class
// depends on mme_pkg and the rtl under rtl/; runs directed then random load/run words

module tb_top;

   localparam logic [mme_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int ITEM_GOAL    = 280;
   localparam int DRAIN_CYCLES = 8;
   localparam int QUIET_LIMIT  = 4000;

   typedef struct packed {
      logic signed [mme_pkg::SUM_W-1:0] product_sum;
      logic [mme_pkg::POS_W-1:0]        row;
      logic [mme_pkg::POS_W-1:0]        col;
      logic                             last_flag;
   } product_word_type;

   class product_tracker;
      logic [mme_pkg::ELEM_W-1:0] matrix_a [mme_pkg::DEPTH];
      logic [mme_pkg::ELEM_W-1:0] matrix_b [mme_pkg::DEPTH];
      logic [mme_pkg::DIM_W-1:0]  rows_a;
      logic [mme_pkg::DIM_W-1:0]  inner_dim;
      logic [mme_pkg::DIM_W-1:0]  cols_b;
      product_word_type           pending_products [$];
      int                         errors;

      function new();
         for (int i = 0; i < mme_pkg::DEPTH; i++) begin
            matrix_a[i] = '0;
            matrix_b[i] = '0;
         end
         rows_a = 4'd1;
         inner_dim = 4'd1;
         cols_b = 4'd1;
         errors = 0;
      endfunction

      static function int clip_dim(logic [mme_pkg::DIM_W-1:0] v);
         return (v > mme_pkg::MAX_DIM) ? mme_pkg::MAX_DIM : int'(v);
      endfunction

      function void set_dim(logic [mme_pkg::CSR_INDEX_W-1:0] index,
                            logic [mme_pkg::DIM_W-1:0] value);
         case (index)
            mme_pkg::CSR_ROWS_A:    rows_a = value;
            mme_pkg::CSR_INNER_DIM: inner_dim = value;
            mme_pkg::CSR_COLS_B:    cols_b = value;
            default: ;
         endcase
      endfunction

      function void note_request(logic [mme_pkg::FUNC_W-1:0] f,
                                 logic [mme_pkg::ADDR_W-1:0] idx,
                                 logic [mme_pkg::ELEM_W-1:0] val);
         int               nr;
         int               nk;
         int               nc;
         longint           acc;
         product_word_type w;
         case (f)
            mme_pkg::FUNC_LOAD_A: matrix_a[idx] = val;
            mme_pkg::FUNC_LOAD_B: matrix_b[idx] = val;
            mme_pkg::FUNC_RUN: begin
               nr = clip_dim(rows_a);
               nk = clip_dim(inner_dim);
               nc = clip_dim(cols_b);
               for (int r = 0; r < nr; r++) begin
                  for (int c = 0; c < nc; c++) begin
                     acc = 0;
                     for (int k = 0; k < nk; k++)
                        acc += longint'($signed(matrix_a[r*nk+k]))
                             * longint'($signed(matrix_b[k*nc+c]));
                     w.product_sum = acc[mme_pkg::SUM_W-1:0];
                     w.row = r[mme_pkg::POS_W-1:0];
                     w.col = c[mme_pkg::POS_W-1:0];
                     w.last_flag = (r == nr - 1) && (c == nc - 1);
                     pending_products.push_back(w);
                  end
               end
            end
            default: ;
         endcase
      endfunction

      function void flag(string what, longint expected, longint actual);
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, what,
                  expected, actual);
         errors++;
      endfunction

      function void check_product(logic signed [mme_pkg::SUM_W-1:0] sum,
                                  logic [mme_pkg::POS_W-1:0] row,
                                  logic [mme_pkg::POS_W-1:0] col, logic last_flag);
         product_word_type w;
         if (pending_products.size() == 0) begin
            $display("%0t: unexpected result word, expected none actual sum %0d row %0d col %0d",
                     $time, sum, row, col);
            errors++;
            return;
         end
         w = pending_products.pop_front();
         if (sum !== w.product_sum) flag("product_sum", w.product_sum, sum);
         if (row !== w.row) flag("out_row", w.row, row);
         if (col !== w.col) flag("out_col", w.col, col);
         if (last_flag !== w.last_flag) flag("last_result", w.last_flag, last_flag);
      endfunction

      function void report_leftover();
         if (pending_products.size() != 0) begin
            $display("%0t: %0d result words never arrived, expected row %0d col %0d next",
                     $time, pending_products.size(), pending_products[0].row,
                     pending_products[0].col);
            errors++;
         end
      endfunction
   endclass

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                start = 1'b0;
   logic                                busy;
   logic [mme_pkg::FUNC_W-1:0]          req_func = mme_pkg::FUNC_LOAD_A;
   logic [mme_pkg::ADDR_W-1:0]          req_element_index = '0;
   logic signed [mme_pkg::ELEM_W-1:0]   req_element_value = '0;
   logic                                rsp_strobe;
   logic signed [mme_pkg::SUM_W-1:0]    rsp_product_sum;
   logic [mme_pkg::POS_W-1:0]           rsp_out_row;
   logic [mme_pkg::POS_W-1:0]           rsp_out_col;
   logic                                rsp_last_result;
   logic                                csr_write_enable = 1'b0;
   logic [mme_pkg::CSR_INDEX_W-1:0]     csr_index = mme_pkg::CSR_ROWS_A;
   logic [mme_pkg::CSR_DATA_W-1:0]      csr_write_data = '0;

   product_tracker tracker = new();
   bit             a_loaded [mme_pkg::DEPTH];
   bit             b_loaded [mme_pkg::DEPTH];
   int             items_sent = 0;
   bit             calm = 1'b0;
   int             quiet_cycles = 0;

   matrix_multiply_engine dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_element_index (req_element_index),
      .req_element_value (req_element_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_product_sum   (rsp_product_sum),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_last_result   (rsp_last_result),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         tracker.check_product(rsp_product_sum, rsp_out_row, rsp_out_col, rsp_last_result);
   end

   // watchdog: cycles without any accepted word, result or register write
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_write_enable) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   function automatic logic [mme_pkg::ELEM_W-1:0] rand_elem();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         default: return mme_pkg::ELEM_W'($urandom);
      endcase
   endfunction

   function automatic logic [mme_pkg::DIM_W-1:0] pick_dim();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 5) return 4'd0;
      if (roll < 12) return 4'd8;
      if (roll < 18) return mme_pkg::DIM_W'($urandom_range(9, 15));
      return mme_pkg::DIM_W'($urandom_range(1, 4));
   endfunction

   task automatic maybe_idle();
      if (!calm && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task automatic send_word(input logic [mme_pkg::FUNC_W-1:0] f,
                            input logic [mme_pkg::ADDR_W-1:0] idx,
                            input logic [mme_pkg::ELEM_W-1:0] val);
      req_func <= f;
      req_element_index <= idx;
      req_element_value <= val;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      tracker.note_request(f, idx, val);
      if (f == mme_pkg::FUNC_LOAD_A) a_loaded[idx] = 1'b1;
      if (f == mme_pkg::FUNC_LOAD_B) b_loaded[idx] = 1'b1;
      items_sent++;
      maybe_idle();
   endtask

   // hold off until every expected word is out and the engine has gone quiet
   task automatic settle_idle();
      start <= 1'b0;
      while (tracker.pending_products.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_dims(input logic [mme_pkg::DIM_W-1:0] r,
                             input logic [mme_pkg::DIM_W-1:0] k,
                             input logic [mme_pkg::DIM_W-1:0] c);
      settle_idle();
      csr_write_enable <= 1'b1;
      csr_index <= mme_pkg::CSR_ROWS_A;
      csr_write_data <= r;
      @(posedge clock);
      tracker.set_dim(mme_pkg::CSR_ROWS_A, r);
      csr_index <= mme_pkg::CSR_INNER_DIM;
      csr_write_data <= k;
      @(posedge clock);
      tracker.set_dim(mme_pkg::CSR_INNER_DIM, k);
      csr_index <= mme_pkg::CSR_COLS_B;
      csr_write_data <= c;
      @(posedge clock);
      tracker.set_dim(mme_pkg::CSR_COLS_B, c);
      csr_write_enable <= 1'b0;
   endtask

   task automatic maybe_noise();
      if ($urandom_range(0, 9) == 0) begin
         case ($urandom_range(0, 2))
            0: send_word(FUNC_UNUSED, mme_pkg::ADDR_W'($urandom),
                         mme_pkg::ELEM_W'($urandom));
            1: send_word(mme_pkg::FUNC_LOAD_A, mme_pkg::ADDR_W'($urandom), rand_elem());
            default: send_word(mme_pkg::FUNC_LOAD_B, mme_pkg::ADDR_W'($urandom),
                               rand_elem());
         endcase
      end
   endtask

   // load whatever the next runs will read, refresh some of it, then run
   task automatic run_phase(input logic [mme_pkg::DIM_W-1:0] r,
                            input logic [mme_pkg::DIM_W-1:0] k,
                            input logic [mme_pkg::DIM_W-1:0] c, input int n_runs);
      int nr;
      int nk;
      int nc;
      nr = product_tracker::clip_dim(r);
      nk = product_tracker::clip_dim(k);
      nc = product_tracker::clip_dim(c);
      write_dims(r, k, c);
      for (int n = 0; n < n_runs; n++) begin
         for (int i = 0; i < nr * nk; i++) begin
            if (!a_loaded[i] || $urandom_range(0, 2) == 0)
               send_word(mme_pkg::FUNC_LOAD_A, mme_pkg::ADDR_W'(i), rand_elem());
            maybe_noise();
         end
         for (int j = 0; j < nk * nc; j++) begin
            if (!b_loaded[j] || $urandom_range(0, 2) == 0)
               send_word(mme_pkg::FUNC_LOAD_B, mme_pkg::ADDR_W'(j), rand_elem());
            maybe_noise();
         end
         send_word(mme_pkg::FUNC_RUN, mme_pkg::ADDR_W'($urandom),
                   mme_pkg::ELEM_W'($urandom));
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: full-scale operands, unused code, top index, zero and degenerate dims
      write_dims(4'd2, 4'd2, 4'd2);
      send_word(mme_pkg::FUNC_LOAD_A, 6'd0, 16'h8000);
      send_word(mme_pkg::FUNC_LOAD_A, 6'd1, 16'h8000);
      send_word(mme_pkg::FUNC_LOAD_A, 6'd2, 16'h7fff);
      send_word(mme_pkg::FUNC_LOAD_A, 6'd3, 16'h8000);
      send_word(mme_pkg::FUNC_LOAD_B, 6'd0, 16'h8000);
      send_word(mme_pkg::FUNC_LOAD_B, 6'd1, 16'h7fff);
      send_word(mme_pkg::FUNC_LOAD_B, 6'd2, 16'h8000);
      send_word(mme_pkg::FUNC_LOAD_B, 6'd3, 16'h0001);
      send_word(mme_pkg::FUNC_RUN, 6'd0, 16'h0000);
      send_word(FUNC_UNUSED, 6'h3f, 16'hffff);
      send_word(mme_pkg::FUNC_LOAD_A, 6'h3f, 16'h5a5a);
      send_word(mme_pkg::FUNC_LOAD_B, 6'h3f, 16'ha5a5);
      write_dims(4'd0, 4'd2, 4'd2);
      send_word(mme_pkg::FUNC_RUN, 6'h2a, 16'h1234);
      write_dims(4'd2, 4'd2, 4'd0);
      send_word(mme_pkg::FUNC_RUN, 6'h15, 16'hedcb);
      write_dims(4'd2, 4'd0, 4'd2);
      send_word(mme_pkg::FUNC_RUN, 6'd0, 16'h0000);
      write_dims(4'd1, 4'd2, 4'd1);
      send_word(mme_pkg::FUNC_RUN, 6'd0, 16'h0000);

      // oversized registers clip to full size; this also fills both stores
      run_phase(4'd15, 4'd8, 4'd12, 1);
      while (items_sent < ITEM_GOAL) begin
         if (items_sent > ITEM_GOAL - 50)
            calm = 1'b1;
         run_phase(pick_dim(), pick_dim(), pick_dim(), $urandom_range(1, 3));
      end

      settle_idle();
      tracker.report_leftover();
      if (tracker.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
